/* rtl/gdm_pkg.sv */
// Shared types and constants for the gamepad drive mode mixer.
// Used by every design module of the block and by the testbench; depends on nothing else.
package gdm_pkg;

  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_DEADZONE    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_WEAPON_FULL = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_WEAPON_HALF = 2'd2;

  localparam logic [7:0] DEADZONE_RST    = 8'd20;
  localparam logic [7:0] WEAPON_FULL_RST = 8'd255;
  localparam logic [7:0] WEAPON_HALF_RST = 8'd128;

  // Trigger and stick mapping constants.
  localparam logic signed [10:0] SPEED_OFFSET = 11'sd255;
  localparam logic signed [11:0] STICK_OFFSET = 12'sd512;
  localparam logic signed [20:0] TURN_GAIN    = 21'sd446;
  localparam logic signed [10:0] TURN_OFFSET  = 11'sd223;
  localparam logic signed [10:0] SIDE_MAX     = 11'sd255;
  localparam logic [10:0]        TRIG_DIV     = 11'd1023;

  typedef struct packed {
    logic [7:0] deadzone;
    logic [7:0] weapon_full;
    logic [7:0] weapon_half;
  } cfg_t;

  typedef struct packed {
    logic       manual;
    logic [7:0] weapon;
  } mode_t;

  typedef struct packed {
    logic a;
    logic b;
    logic x;
    logic y;
  } buttons_t;

endpackage

/* rtl/gdm_cfg_regs.sv */
// Configuration register file: deadzone and the two weapon levels.
// Depends on gdm_pkg.
module gdm_cfg_regs import gdm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [CfgIdxW-1:0] wr_index,
  input  logic [7:0]         wr_data,
  output cfg_t               cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadzone    <= DEADZONE_RST;
      cfg_r.weapon_full <= WEAPON_FULL_RST;
      cfg_r.weapon_half <= WEAPON_HALF_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DEADZONE:    cfg_r.deadzone    <= wr_data;
        REG_WEAPON_FULL: cfg_r.weapon_full <= wr_data;
        REG_WEAPON_HALF: cfg_r.weapon_half <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/gdm_mode_ctrl.sv */
// Button edge detection and the manual mode / weapon level state.
// Depends on gdm_pkg.
module gdm_mode_ctrl import gdm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     advance,
  input  buttons_t buttons,
  input  cfg_t     cfg,
  output mode_t    mode_nxt
);

  buttons_t prev_r;
  mode_t    mode_r;
  buttons_t rise;

  assign rise = buttons & ~prev_r;

  // The presses are applied in order A, B, X, Y, each seeing the one before.
  always_comb begin
    mode_nxt = mode_r;
    if (rise.a) begin
      mode_nxt.manual = 1'b0;
      mode_nxt.weapon = '0;
    end
    if (rise.b) begin
      if (!mode_nxt.manual) begin
        mode_nxt.manual = 1'b1;
      end else begin
        mode_nxt.manual = 1'b0;
        mode_nxt.weapon = '0;
      end
    end
    if (rise.x) begin
      mode_nxt.weapon = (mode_nxt.weapon == cfg.weapon_full) ? '0 : cfg.weapon_full;
    end
    if (rise.y) begin
      mode_nxt.weapon = (mode_nxt.weapon == cfg.weapon_half) ? '0 : cfg.weapon_half;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      mode_r <= '0;
    end else if (advance) begin
      prev_r <= buttons;
      mode_r <= mode_nxt;
    end
  end

endmodule

/* rtl/gdm_mixer.sv */
// Arcade drive mixing: trigger and stick mapping, deadzone, clamp, sign split.
// Pure combinational; depends on gdm_pkg.
module gdm_mixer import gdm_pkg::*; (
  input  logic               manual,
  input  logic [7:0]         deadzone,
  input  logic signed [10:0] stick_x,
  input  logic [9:0]         brake_level,
  input  logic [9:0]         throttle_level,
  output logic [7:0]         left_speed,
  output logic               left_forward,
  output logic [7:0]         right_speed,
  output logic               right_forward
);

  logic [10:0]        trig_sum;
  logic [18:0]        trig_prod;
  logic [8:0]         quot0;
  logic [10:0]        rem;
  logic [8:0]         quot;
  logic signed [10:0] speed;
  logic signed [11:0] stick_ofs;
  logic signed [20:0] turn_prod;
  logic signed [20:0] turn_adj;
  logic signed [20:0] turn_shift;
  logic signed [10:0] turn;
  logic signed [10:0] left_raw;
  logic signed [10:0] right_raw;
  logic signed [10:0] dz;

  // throttle - brake + 1023, always in 0..2046.
  assign trig_sum  = {1'b0, throttle_level} + {1'b0, ~brake_level};
  assign trig_prod = {trig_sum, 8'b0} - {8'b0, trig_sum};

  // Divide by 1023: p = 1024*q0 + low, so p - 1023*q0 = low + q0, which stays
  // below twice the divisor and needs at most one correction.
  assign quot0 = trig_prod[18:10];
  assign rem   = {1'b0, trig_prod[9:0]} + {2'b0, quot0};
  assign quot  = quot0 + {8'b0, (rem >= TRIG_DIV)};
  assign speed = $signed({2'b0, quot}) - SPEED_OFFSET;

  // The turn division truncates toward zero, so negative products are biased.
  assign stick_ofs  = {stick_x[10], stick_x} + STICK_OFFSET;
  assign turn_prod  = {{9{stick_ofs[11]}}, stick_ofs} * TURN_GAIN;
  assign turn_adj   = turn_prod + (turn_prod[20] ? 21'sd1023 : 21'sd0);
  assign turn_shift = turn_adj >>> 10;
  assign turn       = turn_shift[10:0] - TURN_OFFSET;

  assign left_raw  = speed + turn;
  assign right_raw = speed - turn;
  assign dz        = $signed({3'b0, deadzone});

  function automatic logic [8:0] side_out(input logic signed [10:0] v,
                                          input logic signed [10:0] dzv);
    logic signed [10:0] c;
    logic [10:0]        mag;
    begin
      if (v < dzv && v > -dzv) begin
        c = '0;
      end else if (v > SIDE_MAX) begin
        c = SIDE_MAX;
      end else if (v < -SIDE_MAX) begin
        c = -SIDE_MAX;
      end else begin
        c = v;
      end
      mag = c[10] ? 11'(-c) : 11'(c);
      side_out = {~c[10], mag[7:0]};
    end
  endfunction

  logic [8:0] left_o;
  logic [8:0] right_o;

  assign left_o  = side_out(left_raw, dz);
  assign right_o = side_out(right_raw, dz);

  assign left_speed    = manual ? left_o[7:0]  : 8'd0;
  assign left_forward  = manual ? left_o[8]    : 1'b1;
  assign right_speed   = manual ? right_o[7:0] : 8'd0;
  assign right_forward = manual ? right_o[8]   : 1'b1;

endmodule

/* rtl/gamepad_drive_mode_mixer_top.sv */
// Gamepad drive mode mixer, top level.
// Depends on gdm_pkg, gdm_cfg_regs, gdm_mode_ctrl and gdm_mixer.
//
// One gamepad report in, one drive and weapon command out. The block takes a
// request every clock cycle while the result side does not stall: the report
// is captured in an input register, and the button handling and drive mixing
// run in one pass into the result register, which is the only place where
// mode state advances. When the result side stalls, the input register holds
// one more report and then stalls the input. Configuration writes are always
// ready and take effect on every report that leaves the input register after them.
module gamepad_drive_mode_mixer_top import gdm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_button_a,
  input  logic               in_button_b,
  input  logic               in_button_x,
  input  logic               in_button_y,
  input  logic signed [10:0] in_stick_x,
  input  logic [9:0]         in_brake_level,
  input  logic [9:0]         in_throttle_level,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_left_speed,
  output logic               out_left_forward,
  output logic [7:0]         out_right_speed,
  output logic               out_right_forward,
  output logic [7:0]         out_weapon_level,
  output logic               out_manual_on,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [7:0]         cfg_data
);

  cfg_t     cfg;
  mode_t    mode_nxt;
  buttons_t btn_r;

  logic               s1_valid_r;
  logic signed [10:0] stick_r;
  logic [9:0]         brake_r;
  logic [9:0]         throttle_r;
  logic               advance;
  logic               in_take;

  logic [7:0] left_speed;
  logic       left_forward;
  logic [7:0] right_speed;
  logic       right_forward;

  assign cfg_ready = 1'b1;

  // The input register moves forward whenever the result register is free.
  assign advance  = s1_valid_r && (!out_valid || !out_stall);
  assign in_stall = s1_valid_r && !(!out_valid || !out_stall);
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      btn_r      <= '{a: in_button_a, b: in_button_b, x: in_button_x, y: in_button_y};
      stick_r    <= in_stick_x;
      brake_r    <= in_brake_level;
      throttle_r <= in_throttle_level;
    end
  end

  gdm_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  gdm_mode_ctrl u_mode (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .buttons  (btn_r),
    .cfg      (cfg),
    .mode_nxt (mode_nxt)
  );

  gdm_mixer u_mix (
    .manual         (mode_nxt.manual),
    .deadzone       (cfg.deadzone),
    .stick_x        (stick_r),
    .brake_level    (brake_r),
    .throttle_level (throttle_r),
    .left_speed     (left_speed),
    .left_forward   (left_forward),
    .right_speed    (right_speed),
    .right_forward  (right_forward)
  );

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_left_speed    <= left_speed;
      out_left_forward  <= left_forward;
      out_right_speed   <= right_speed;
      out_right_forward <= right_forward;
      out_weapon_level  <= mode_nxt.weapon;
      out_manual_on     <= mode_nxt.manual;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/gdm_checker.sv */
// Port-level checks for the gamepad drive mode mixer, bound to the top level.
// Depends on gamepad_drive_mode_mixer_top's port list only.
module gdm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_left_speed,
  input logic       out_left_forward,
  input logic [7:0] out_right_speed,
  input logic       out_right_forward,
  input logic [7:0] out_weapon_level,
  input logic       out_manual_on
);

  // A held result keeps its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_left_speed)
      && $stable(out_right_speed) && $stable(out_weapon_level)
      && $stable(out_manual_on))
    else $error("stalled result changed");

  // Outside manual mode both sides stop and point forward.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_manual_on |-> out_left_speed == 8'd0 && out_right_speed == 8'd0
      && out_left_forward && out_right_forward)
    else $error("drive active outside manual mode");

  // A zero magnitude always reports the forward direction.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_left_speed == 8'd0 || out_right_speed == 8'd0) |->
      (out_left_speed != 8'd0 || out_left_forward)
      && (out_right_speed != 8'd0 || out_right_forward))
    else $error("zero speed with reverse direction");

  // Reset empties the pipeline.
  assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind gamepad_drive_mode_mixer_top gdm_checker u_gdm_checker (.*);

/* tb/sv/gamepad_drive_mode_mixer_top_test.sv */
// Self-checking testbench for gamepad_drive_mode_mixer_top: directed reports, then
// random reports under several register settings and idle patterns.
// Depends on gdm_pkg and the gamepad_drive_mode_mixer_top RTL only.
module gamepad_drive_mode_mixer_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gdm_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;
  localparam int DRIVE_MAX = 255;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES = 8;
  localparam int PHASE_REPORTS = 205;

  typedef struct packed {
    buttons_t           btn;
    logic signed [10:0] stick;
    logic [9:0]         brake;
    logic [9:0]         throttle;
  } report_t;

  typedef struct packed {
    logic [7:0] left_speed;
    logic       left_fwd;
    logic [7:0] right_speed;
    logic       right_fwd;
    logic [7:0] weapon;
    logic       manual;
  } command_t;

  typedef struct packed {
    logic     pinned;
    command_t cmd;
  } pinned_cmd_t;

  // Buttons are written a, b, x, y. Rows with pinned set carry their expected command.
  typedef struct packed {
    logic [3:0] btn;
    int         stick;
    int         brake;
    int         throttle;
    logic       pinned;
    int         ls;
    int         lf;
    int         rs;
    int         rf;
    int         weapon;
    int         manual;
  } directed_step_t;

  localparam directed_step_t DIRECTED_STEPS [25] = '{
    '{4'b0000, 1023, 1023, 1023, 1'b1, 0, 1, 0, 1, 0, 0},
    '{4'b0010, 0, 0, 0, 1'b1, 0, 1, 0, 1, 255, 0},
    '{4'b0010, -1, 5, 7, 1'b1, 0, 1, 0, 1, 255, 0},
    '{4'b0001, 0, 0, 0, 1'b1, 0, 1, 0, 1, 128, 0},
    '{4'b0011, 0, 0, 0, 1'b1, 0, 1, 0, 1, 255, 0},
    '{4'b0000, 0, 0, 0, 1'b1, 0, 1, 0, 1, 255, 0},
    '{4'b0010, 0, 0, 0, 1'b1, 0, 1, 0, 1, 0, 0},
    '{4'b0001, 0, 0, 0, 1'b1, 0, 1, 0, 1, 128, 0},
    '{4'b0000, 0, 0, 0, 1'b1, 0, 1, 0, 1, 128, 0},
    '{4'b0001, 0, 0, 0, 1'b1, 0, 1, 0, 1, 0, 0},
    '{4'b0100, 0, 0, 0, 1'b1, 0, 1, 0, 1, 0, 1},
    '{4'b0100, 0, 0, 1023, 1'b1, 255, 1, 255, 1, 0, 1},
    '{4'b0100, 0, 1023, 0, 1'b1, 255, 0, 255, 0, 0, 1},
    '{4'b0100, 512, 0, 0, 1'b1, 223, 1, 223, 0, 0, 1},
    '{4'b0100, -512, 0, 0, 1'b1, 223, 0, 223, 1, 0, 1},
    '{4'b0100, 1023, 0, 1023, 1'b0, 0, 0, 0, 0, 0, 0},
    '{4'b0100, -1024, 1023, 0, 1'b0, 0, 0, 0, 0, 0, 0},
    '{4'b0100, 30, 0, 0, 1'b0, 0, 0, 0, 0, 0, 0},
    '{4'b1010, 0, 0, 1023, 1'b1, 0, 1, 0, 1, 255, 0},
    '{4'b0100, 0, 512, 512, 1'b0, 0, 0, 0, 0, 0, 0},
    '{4'b0000, 100, 300, 700, 1'b0, 0, 0, 0, 0, 0, 0},
    '{4'b0100, 0, 0, 0, 1'b1, 0, 1, 0, 1, 0, 0},
    '{4'b0000, -300, 1000, 20, 1'b1, 0, 1, 0, 1, 0, 0},
    '{4'b1111, 200, 100, 900, 1'b0, 0, 0, 0, 0, 0, 0},
    '{4'b0101, -200, 900, 100, 1'b0, 0, 0, 0, 0, 0, 0}
  };

  localparam cfg_t REG_SETS [5] = '{
    '{DEADZONE_RST, WEAPON_FULL_RST, WEAPON_HALF_RST},
    '{8'd0, 8'd0, 8'd0},
    '{8'd255, 8'd255, 8'd255},
    '{8'd1, 8'd128, 8'd128},
    '{8'd255, 8'd0, 8'd1}
  };

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_button_a = 1'b0;
  logic               in_button_b = 1'b0;
  logic               in_button_x = 1'b0;
  logic               in_button_y = 1'b0;
  logic signed [10:0] in_stick_x = '0;
  logic [9:0]         in_brake_level = '0;
  logic [9:0]         in_throttle_level = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_left_speed;
  logic               out_left_forward;
  logic [7:0]         out_right_speed;
  logic               out_right_forward;
  logic [7:0]         out_weapon_level;
  logic               out_manual_on;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [7:0]         cfg_data = '0;

  // Mirror of the block's registers and mode state.
  cfg_t     cfg_st;
  buttons_t prev_btn;
  mode_t    mode_st;

  command_t    expected_cmds[$];
  pinned_cmd_t pinned_cmds[$];
  buttons_t    held_btn = '0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          quiet_cycles = 0;
  int          send_gap_pct = 0;
  int          stall_pct = 0;
  int          hold_request = 0;

  gamepad_drive_mode_mixer_top u_top (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  task automatic check_field(string field, int got, int want);
    if (got != want)
      report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                results_seen, field, got, want));
  endtask

  function automatic int clamp_drive(int v);
    if (v > DRIVE_MAX) return DRIVE_MAX;
    if (v < -DRIVE_MAX) return -DRIVE_MAX;
    return v;
  endfunction

  function automatic int apply_deadzone(int v);
    int dz;
    dz = int'(cfg_st.deadzone);
    if (v < dz && v > -dz) return 0;
    return clamp_drive(v);
  endfunction

  function automatic void split_side(int v, output logic [7:0] mag, output logic fwd);
    fwd = (v >= 0);
    mag = 8'((v < 0) ? -v : v);
  endfunction

  // Applies button edges in the order A, B, X, Y, then mixes the drive sides.
  function automatic command_t mix_report(report_t rep);
    buttons_t rise;
    int       speed;
    int       turn;
    command_t c;
    rise = rep.btn & ~prev_btn;
    if (rise.a) mode_st = '0;
    if (rise.b) begin
      if (!mode_st.manual) begin
        mode_st.manual = 1'b1;
      end else begin
        mode_st = '0;
      end
    end
    if (rise.x)
      mode_st.weapon = (mode_st.weapon == cfg_st.weapon_full) ? 8'd0 : cfg_st.weapon_full;
    if (rise.y)
      mode_st.weapon = (mode_st.weapon == cfg_st.weapon_half) ? 8'd0 : cfg_st.weapon_half;
    prev_btn = rep.btn;

    c = '0;
    c.left_fwd = 1'b1;
    c.right_fwd = 1'b1;
    if (mode_st.manual) begin
      speed = clamp_drive((int'(rep.throttle) - int'(rep.brake) + 1023) * 510 / 2046 - 255);
      turn = (int'(rep.stick) + 512) * 446 / 1024 - 223;
      split_side(apply_deadzone(speed + turn), c.left_speed, c.left_fwd);
      split_side(apply_deadzone(speed - turn), c.right_speed, c.right_fwd);
    end
    c.weapon = mode_st.weapon;
    c.manual = mode_st.manual;
    return c;
  endfunction

  always @(posedge clk) begin : bus_monitor
    command_t    got;
    command_t    want;
    report_t     rep;
    pinned_cmd_t pin;
    if (!rst_n) begin
      cfg_st = '{DEADZONE_RST, WEAPON_FULL_RST, WEAPON_HALF_RST};
      prev_btn = '0;
      mode_st = '0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_left_speed, out_left_forward, out_right_speed, out_right_forward,
                out_weapon_level, out_manual_on};
        if (expected_cmds.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          want = expected_cmds.pop_front();
          check_field("left_speed", got.left_speed, want.left_speed);
          check_field("left_forward", got.left_fwd, want.left_fwd);
          check_field("right_speed", got.right_speed, want.right_speed);
          check_field("right_forward", got.right_fwd, want.right_fwd);
          check_field("weapon_level", got.weapon, want.weapon);
          check_field("manual_on", got.manual, want.manual);
          results_seen++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEADZONE:    cfg_st.deadzone = cfg_data;
          REG_WEAPON_FULL: cfg_st.weapon_full = cfg_data;
          REG_WEAPON_HALF: cfg_st.weapon_half = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        rep = '{'{in_button_a, in_button_b, in_button_x, in_button_y}, in_stick_x,
                in_brake_level, in_throttle_level};
        pin = pinned_cmds.pop_front();
        want = mix_report(rep);
        expected_cmds.push_back(pin.pinned ? pin.cmd : want);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_report(report_t rep, logic pinned, command_t cmd);
    pinned_cmds.push_back('{pinned, cmd});
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_button_a <= rep.btn.a;
    in_button_b <= rep.btn.b;
    in_button_x <= rep.btn.x;
    in_button_y <= rep.btn.y;
    in_stick_x <= rep.stick;
    in_brake_level <= rep.brake;
    in_throttle_level <= rep.throttle;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // The extra edge lets the monitor record the last accepted request first.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_regs(cfg_t regs);
    write_reg(REG_DEADZONE, regs.deadzone);
    write_reg(REG_WEAPON_FULL, regs.weapon_full);
    write_reg(REG_WEAPON_HALF, regs.weapon_half);
    write_reg(REG_UNUSED, 8'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic int clip_trigger(int v);
    if (v < 0) return 0;
    if (v > 1023) return 1023;
    return v;
  endfunction

  // Buttons mostly follow a held level with occasional presses, so that manual mode and
  // weapon toggles see long runs; a few reports carry arbitrary button patterns.
  function automatic report_t random_report();
    report_t rep;
    int      t;
    if ($urandom_range(99) < 8) begin
      held_btn = buttons_t'(4'($urandom_range(15)));
    end else begin
      held_btn.a = ($urandom_range(99) < 3);
      if ($urandom_range(99) < 12) held_btn.b = ~held_btn.b;
      if ($urandom_range(99) < 15) held_btn.x = ~held_btn.x;
      if ($urandom_range(99) < 15) held_btn.y = ~held_btn.y;
    end
    rep.btn = held_btn;
    rep.brake = 10'($urandom_range(1023));
    rep.throttle = 10'($urandom_range(1023));
    case ($urandom_range(9))
      0: rep.stick = 11'($urandom_range(2047));
      1: begin
        case ($urandom_range(4))
          0: rep.stick = -11'sd1024;
          1: rep.stick = -11'sd512;
          2: rep.stick = 11'sd0;
          3: rep.stick = 11'sd512;
          default: rep.stick = 11'sd1023;
        endcase
        rep.brake = $urandom_range(1) ? 10'd1023 : 10'd0;
        rep.throttle = $urandom_range(1) ? 10'd1023 : 10'd0;
      end
      2, 3: begin
        // Near the center, where the deadzone decides.
        t = int'(rep.throttle) + int'($urandom_range(80)) - 40;
        rep.brake = 10'(clip_trigger(t));
        rep.stick = 11'(int'($urandom_range(60)) - 30);
      end
      default: rep.stick = 11'(int'($urandom_range(1024)) - 512);
    endcase
    return rep;
  endfunction

  initial begin : stimulus
    cfg_t           regs;
    report_t        rep;
    command_t       cmd;
    directed_step_t s;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_STEPS[i]) begin
      s = DIRECTED_STEPS[i];
      rep.btn = buttons_t'(s.btn);
      rep.stick = 11'(s.stick);
      rep.brake = 10'(s.brake);
      rep.throttle = 10'(s.throttle);
      cmd.left_speed = 8'(s.ls);
      cmd.left_fwd = s.lf[0];
      cmd.right_speed = 8'(s.rs);
      cmd.right_fwd = s.rf[0];
      cmd.weapon = 8'(s.weapon);
      cmd.manual = s.manual[0];
      send_report(rep, s.pinned, cmd);
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      if (p < 5) begin
        regs = REG_SETS[p];
      end else begin
        regs = '{8'($urandom_range(63)), 8'($urandom_range(255)), 8'($urandom_range(255))};
      end
      program_regs(regs);
      case (p % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 70; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 70; end
        default: begin send_gap_pct = 35; stall_pct = 35; end
      endcase
      for (int i = 0; i < PHASE_REPORTS; i++) begin
        // The sender keeps offering reports while the result side is held off.
        if (p == 0 && i == 60) hold_request = HOLD_CYCLES;
        if (p == 5 && i == 100) drain_results();
        send_report(random_report(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* gamepad_drive_mode_mixer_top.f */
rtl/gdm_pkg.sv
rtl/gdm_cfg_regs.sv
rtl/gdm_mode_ctrl.sv
rtl/gdm_mixer.sv
rtl/gamepad_drive_mode_mixer_top.sv
rtl/gdm_checker.sv
tb/sv/gamepad_drive_mode_mixer_top_test.sv
